### rtl/brtq_pkg.sv
// Package: sizes, opcodes and stage word types for the bounded ring task queue.
`default_nettype none
package brtq_pkg;

  localparam int DEPTH      = 16;
  localparam int TASK_WIDTH = 64;
  localparam int PTR_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W      = $clog2(DEPTH + 1);
  localparam int LEN_W      = $clog2(DEPTH + 1);

  localparam logic OP_ENQUEUE = 1'b0;
  localparam logic OP_DEQUEUE = 1'b1;

  typedef struct packed {
    logic                  valid;
    logic                  op;
    logic [TASK_WIDTH-1:0] word;
  } cmd_t;

  typedef struct packed {
    logic                  accepted;
    logic [TASK_WIDTH-1:0] task_out;
    logic                  present;
    logic [CNT_W-1:0]      count;
  } res_t;

endpackage
`default_nettype wire

### rtl/brtq_cmd_stage.sv
// Input register: captures one command word per accepted start.
`default_nettype none
module brtq_cmd_stage (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            take,
  input  wire logic                            operation,
  input  wire logic [brtq_pkg::TASK_WIDTH-1:0] task_word,
  output brtq_pkg::cmd_t                       cmd
);
  import brtq_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cmd.valid <= 1'b0;
    end else begin
      cmd.valid <= take;
    end
    if (take) begin
      cmd.op   <= operation;
      cmd.word <= task_word;
    end
  end

endmodule
`default_nettype wire

### rtl/brtq_ring.sv
// Ring state: slot store, valid marks, pointers, occupancy and the per-command update.
`default_nettype none
module brtq_ring (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire brtq_pkg::cmd_t             cmd,
  input  wire logic [brtq_pkg::LEN_W-1:0] eff_len,
  output brtq_pkg::res_t                  res
);
  import brtq_pkg::*;

  logic [TASK_WIDTH-1:0] slot_store [DEPTH];
  logic [DEPTH-1:0]      slot_valid;
  logic [PTR_W-1:0]      head_pointer, head_pointer_next;
  logic [PTR_W-1:0]      tail_pointer, tail_pointer_next;
  logic [CNT_W-1:0]      occupancy, occupancy_next;
  logic                  wr_en;
  logic                  clr_en;

  // next pointer, back to slot 0 at the ring end (also from beyond a shortened ring)
  function automatic logic [PTR_W-1:0] advance(input logic [PTR_W-1:0] ptr,
                                               input logic [LEN_W-1:0] len);
    logic [LEN_W-1:0] n;
    n = LEN_W'(ptr) + LEN_W'(1);
    return (n >= len) ? '0 : PTR_W'(n);
  endfunction

  always_comb begin
    head_pointer_next = head_pointer;
    tail_pointer_next = tail_pointer;
    occupancy_next    = occupancy;
    wr_en             = 1'b0;
    clr_en            = 1'b0;
    res.accepted      = 1'b0;
    res.task_out      = '0;
    res.present       = 1'b0;
    if (cmd.valid) begin
      if (cmd.op == OP_ENQUEUE) begin
        if (occupancy < eff_len) begin
          wr_en             = 1'b1;
          tail_pointer_next = advance(tail_pointer, eff_len);
          occupancy_next    = occupancy + CNT_W'(1);
          res.accepted      = 1'b1;
        end
      end else begin
        if (slot_valid[head_pointer]) begin
          clr_en            = 1'b1;
          head_pointer_next = advance(head_pointer, eff_len);
          if (occupancy != '0) begin
            occupancy_next = occupancy - CNT_W'(1);
          end
          res.accepted = 1'b1;
          res.task_out = slot_store[head_pointer];
          res.present  = 1'b1;
        end
      end
    end
    res.count = occupancy_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid   <= '0;
      head_pointer <= '0;
      tail_pointer <= '0;
      occupancy    <= '0;
    end else begin
      head_pointer <= head_pointer_next;
      tail_pointer <= tail_pointer_next;
      occupancy    <= occupancy_next;
      if (wr_en) begin
        slot_valid[tail_pointer] <= 1'b1;
      end
      if (clr_en) begin
        slot_valid[head_pointer] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slot_store[tail_pointer] <= cmd.word;
    end
  end

endmodule
`default_nettype wire

### rtl/brtq_result_stage.sv
// Result register: holds one result word for one cycle with its strobe.
`default_nettype none
module brtq_result_stage (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           res_valid,
  input  wire brtq_pkg::res_t res,
  output logic                done,
  output brtq_pkg::res_t      res_q
);
  import brtq_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= res_valid;
    end
    res_q <= res;
  end

endmodule
`default_nettype wire

### rtl/bounded_ring_task_queue_core.sv
// Top level of the bounded ring task queue: config register, stages and checks.
//
//  channel  | ports                                        | handshake
//  ---------+----------------------------------------------+---------------------------
//  command  | operation, task_word                         | start & !busy at clk edge
//  result   | accepted, task_out, task_present, entry_count| done high for one cycle
//  config   | cfg_data (ring_length)                       | cfg_write at clk edge
//
//  Cycles: one command word per cycle outside reset; done rises with the result word in
//    the result register, once the command has passed the input register and the ring
//    update (path: input register, ring update, result register).
//  Reset: rst is synchronous; it clears pointers, occupancy and all 16 valid marks
//    and sets ring_length to 16. busy is high only during reset.
//  Stalls: none. The receiver takes every result word; nothing holds the pipe.
`default_nettype none
module bounded_ring_task_queue_core (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            start,
  output logic                                 busy,
  input  wire logic                            operation,
  input  wire logic [brtq_pkg::TASK_WIDTH-1:0] task_word,
  input  wire logic                            cfg_write,
  input  wire logic [brtq_pkg::LEN_W-1:0]      cfg_data,
  output logic                                 done,
  output logic                                 accepted,
  output logic [brtq_pkg::TASK_WIDTH-1:0]      task_out,
  output logic                                 task_present,
  output logic [brtq_pkg::CNT_W-1:0]           entry_count
);
  import brtq_pkg::*;

  logic [LEN_W-1:0] ring_length;
  logic [LEN_W-1:0] eff_len;
  logic             take;
  cmd_t             cmd;
  res_t             res;
  res_t             res_q;

  // the pipe never backs up; only reset blocks new commands
  assign busy = rst;
  assign take = start & ~busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      ring_length <= LEN_W'(DEPTH);
    end else if (cfg_write) begin
      ring_length <= cfg_data;
    end
  end

  // zero acts as one slot, anything past DEPTH acts as DEPTH
  always_comb begin
    if (ring_length == '0) begin
      eff_len = LEN_W'(1);
    end else if (ring_length > LEN_W'(DEPTH)) begin
      eff_len = LEN_W'(DEPTH);
    end else begin
      eff_len = ring_length;
    end
  end

  brtq_cmd_stage u_cmd (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .operation (operation),
    .task_word (task_word),
    .cmd       (cmd)
  );

  brtq_ring u_ring (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .eff_len (eff_len),
    .res     (res)
  );

  brtq_result_stage u_res (
    .clk       (clk),
    .rst       (rst),
    .res_valid (cmd.valid),
    .res       (res),
    .done      (done),
    .res_q     (res_q)
  );

  assign accepted     = res_q.accepted;
  assign task_out     = res_q.task_out;
  assign task_present = res_q.present;
  assign entry_count  = res_q.count;

  // every accepted command yields a result with done, past the input and result registers
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    take |=> ##1 done)
    else $error("accepted command produced no result");

  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(take, 2))
    else $error("result without an accepted command");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    done |-> (entry_count <= CNT_W'(DEPTH)))
    else $error("entry count above ring depth");

  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !task_present) |-> (task_out == '0))
    else $error("task_out nonzero without a dequeued task");

endmodule
`default_nettype wire

### bench/testbench.sv
// Self-checking bench for the bounded ring task queue: queued commands, ring predictor, checks.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import brtq_pkg::*;

  localparam int RESET_CYCLES    = 12;
  localparam int STALL_LIMIT     = 2000; // quiet cycles before we call it hung
  localparam int TAIL_CYCLES     = 8;    // result lags acceptance by the input and result registers; margin on top
  localparam int RANDOM_PER_MODE = 220;  // three idle modes, about 700 words in all
  localparam int IDLE_PLAN [3]   = '{15, 53, 0};

  // One entry of the send list: a command word, a ring_length write, or a drain point
  // where the sender holds off until every predicted result has come back.
  typedef enum logic [1:0] {ITEM_CMD, ITEM_CFG, ITEM_DRAIN} item_kind_t;

  typedef struct {
    item_kind_t            kind;
    logic                  op;
    logic [TASK_WIDTH-1:0] word;
    logic [LEN_W-1:0]      len;
    int                    idle_pct;
  } stim_item_t;

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  start     = 1'b0;
  logic                  operation = OP_ENQUEUE;
  logic [TASK_WIDTH-1:0] task_word = '0;
  logic                  cfg_write = 1'b0;
  logic [LEN_W-1:0]      cfg_data  = '0;
  logic                  busy;
  logic                  done;
  logic                  accepted;
  logic [TASK_WIDTH-1:0] task_out;
  logic                  task_present;
  logic [CNT_W-1:0]      entry_count;

  stim_item_t ops_to_send [$];
  res_t       ring_replies [$];   // predicted result words, oldest first
  int         in_flight    = 0;   // words accepted whose result has not shown up yet
  int         errors       = 0;
  int         quiet_cycles = 0;

  // Shadow of the ring, kept in step with every accepted word.
  logic [TASK_WIDTH-1:0] slot_word [DEPTH];
  logic                  slot_full [DEPTH];
  logic [PTR_W-1:0]      ring_head;
  logic [PTR_W-1:0]      ring_tail;
  logic [CNT_W-1:0]      ring_count;
  logic [LEN_W-1:0]      ring_len;

  bounded_ring_task_queue_core dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .operation    (operation),
    .task_word    (task_word),
    .cfg_write    (cfg_write),
    .cfg_data     (cfg_data),
    .done         (done),
    .accepted     (accepted),
    .task_out     (task_out),
    .task_present (task_present),
    .entry_count  (entry_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Ring predictor
  // ---------------------------------------------------------------------------

  // ring_length is clamped: 0 behaves as 1, anything past DEPTH as DEPTH.
  function automatic int ring_span();
    if (ring_len == 0) return 1;
    if (ring_len > DEPTH) return DEPTH;
    return int'(ring_len);
  endfunction

  // Wrap when the next slot reaches the span; a pointer stranded past a
  // shortened ring therefore snaps back to 0 on its next move.
  function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] ptr);
    int n;
    n = int'(ptr) + 1;
    return (n >= ring_span()) ? '0 : PTR_W'(n);
  endfunction

  function automatic void ring_apply(input logic op, input logic [TASK_WIDTH-1:0] word);
    res_t r;
    r = '0;
    if (op == OP_ENQUEUE) begin
      // Full test uses the count, not the marks, so a ring shortened below its
      // fill refuses until enough words drain. Overwriting a marked slot still counts up.
      if (int'(ring_count) < ring_span()) begin
        slot_word[ring_tail] = word;
        slot_full[ring_tail] = 1'b1;
        ring_tail = ring_next(ring_tail);
        ring_count = ring_count + 1'b1;
        r.accepted = 1'b1;
      end
    end else if (slot_full[ring_head]) begin
      r.task_out = slot_word[ring_head];
      slot_full[ring_head] = 1'b0;
      ring_head = ring_next(ring_head);
      if (ring_count != 0) ring_count = ring_count - 1'b1;
      r.accepted = 1'b1;
      r.present  = 1'b1;
    end
    // empty dequeue: all zero apart from the count, nothing moves
    r.count = ring_count;
    ring_replies.push_back(r);
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: one word presented at a time; ports change only right after an edge.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : drive_commands
    stim_item_t       nxt;
    logic             took;
    logic             nx_start;
    logic             nx_cfg;
    logic             nx_op;
    logic [TASK_WIDTH-1:0] nx_word;
    logic [LEN_W-1:0] nx_len;
    if (rst) begin
      start      <= 1'b0;
      cfg_write  <= 1'b0;
      in_flight  = 0;
      ring_head  = '0;
      ring_tail  = '0;
      ring_count = '0;
      ring_len   = LEN_W'(DEPTH);
      foreach (slot_full[i]) begin
        slot_full[i] = 1'b0;
        slot_word[i] = '0;
      end
    end else begin
      took = start && !busy;
      if (took) ring_apply(operation, task_word);
      if (cfg_write) ring_len = cfg_data;
      // done is sampled from before the edge, so this count is free of races
      in_flight = in_flight + int'(took) - int'(done);

      nx_start = start && !took;   // keep a word up until it is taken
      nx_cfg   = 1'b0;
      nx_op    = operation;
      nx_word  = task_word;
      nx_len   = cfg_data;
      if (!nx_start && ops_to_send.size() != 0) begin
        nxt = ops_to_send[0];
        case (nxt.kind)
          ITEM_CMD: begin
            if ($urandom_range(0, 99) >= nxt.idle_pct) begin
              nx_start = 1'b1;
              nx_op    = nxt.op;
              nx_word  = nxt.word;
              void'(ops_to_send.pop_front());
            end
          end
          ITEM_CFG: begin
            // register writes only with the pipe empty
            if (in_flight == 0) begin
              nx_cfg = 1'b1;
              nx_len = nxt.len;
              void'(ops_to_send.pop_front());
            end
          end
          default: begin
            if (in_flight == 0) void'(ops_to_send.pop_front());
          end
        endcase
      end
      start     <= nx_start;
      operation <= nx_op;
      task_word <= nx_word;
      cfg_write <= nx_cfg;
      cfg_data  <= nx_len;
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: every strobed result word is matched against the oldest prediction.
  // ---------------------------------------------------------------------------
  function automatic void field_check(input string name, input logic [TASK_WIDTH-1:0] want,
                                      input logic [TASK_WIDTH-1:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
    end
  endfunction

  always @(posedge clk) begin : check_results
    res_t want;
    if (!rst && done) begin
      if (ring_replies.size() == 0) begin
        errors++;
        $display("%0t: result word with none expected, actual acc=%0b task=%h pres=%0b cnt=%0d",
                 $time, accepted, task_out, task_present, entry_count);
      end else begin
        want = ring_replies.pop_front();
        field_check("accepted", TASK_WIDTH'(want.accepted), TASK_WIDTH'(accepted));
        field_check("task_out", want.task_out, task_out);
        field_check("task_present", TASK_WIDTH'(want.present), TASK_WIDTH'(task_present));
        field_check("entry_count", TASK_WIDTH'(want.count), TASK_WIDTH'(entry_count));
      end
    end
  end

  // Hang guard: counts cycles where no word, result or register write moves.
  always @(posedge clk) begin : watchdog
    if (rst || (start && !busy) || done || cfg_write) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
      $display("testbench: done, errors");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  function automatic void add_cmd(input logic op, input logic [TASK_WIDTH-1:0] word,
                                  input int idle);
    stim_item_t it;
    it = '{kind: ITEM_CMD, op: op, word: word, len: '0, idle_pct: idle};
    ops_to_send.push_back(it);
  endfunction

  function automatic void add_cfg(input logic [LEN_W-1:0] len);
    stim_item_t it;
    it = '{kind: ITEM_CFG, op: OP_ENQUEUE, word: '0, len: len, idle_pct: 0};
    ops_to_send.push_back(it);
  endfunction

  function automatic void add_drain();
    stim_item_t it;
    it = '{kind: ITEM_DRAIN, op: OP_ENQUEUE, word: '0, len: '0, idle_pct: 0};
    ops_to_send.push_back(it);
  endfunction

  // zero and all-ones tasks show up often enough to matter
  function automatic logic [TASK_WIDTH-1:0] pick_task_word();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // clamp cases (0, above DEPTH) and the two real extremes weigh in heavily
  function automatic logic [LEN_W-1:0] pick_ring_length();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return LEN_W'(1);
      2:       return LEN_W'(DEPTH);
      3:       return LEN_W'($urandom_range(DEPTH + 1, 31));
      default: return LEN_W'($urandom_range(2, DEPTH - 1));
    endcase
  endfunction

  initial begin : run_test
    int segment;
    int sent;
    int span;
    int enq_pct;

    // Directed: empty dequeue, zero and all-ones tasks round trip.
    add_cmd(OP_DEQUEUE, '0, 0);
    add_cmd(OP_ENQUEUE, '0, 0);
    add_cmd(OP_ENQUEUE, '1, 0);
    add_cmd(OP_DEQUEUE, '1, 0);
    add_cmd(OP_DEQUEUE, '0, 0);
    add_cmd(OP_DEQUEUE, '0, 0);
    // Length 0 acts as 1; the tail sits past the ring, so it writes there and wraps.
    add_cfg('0);
    add_cmd(OP_ENQUEUE, 64'h8000_0000_0000_0001, 0);
    add_cmd(OP_ENQUEUE, 64'h7FFF_FFFF_FFFF_FFFE, 0);
    add_cmd(OP_DEQUEUE, '0, 0);
    add_cmd(OP_DEQUEUE, '0, 0);
    // A length above DEPTH, replaced by 4 before any command; then a ring of 4 filled, overfilled, half drained.
    add_cfg(LEN_W'(31));
    add_cfg(LEN_W'(4));
    for (int i = 0; i < 5; i++) add_cmd(OP_ENQUEUE, {$urandom, $urandom}, 0);
    add_cmd(OP_DEQUEUE, '0, 0);
    add_cmd(OP_DEQUEUE, '0, 0);
    // Widen back out: the third enqueue lands on a slot still marked.
    add_cfg(LEN_W'(DEPTH));
    for (int i = 0; i < 3; i++) add_cmd(OP_ENQUEUE, {$urandom, $urandom}, 0);
    for (int i = 0; i < 3; i++) add_cmd(OP_DEQUEUE, '0, 0);
    // Shorten below the fill: enqueue refused, head parked on an empty slot.
    add_cfg(LEN_W'(2));
    add_cmd(OP_ENQUEUE, '1, 0);
    add_cmd(OP_DEQUEUE, '0, 0);

    // Random: segments, most under a fresh ring length, each with its own enqueue bias
    // so the queue swings between full and empty.
    for (int m = 0; m < 3; m++) begin
      sent    = 0;
      segment = 0;
      while (sent < RANDOM_PER_MODE) begin
        if (segment == 1) add_drain();
        if ($urandom_range(0, 3) != 0) add_cfg(pick_ring_length());
        span    = $urandom_range(8, 40);
        enq_pct = $urandom_range(15, 85);
        repeat (span) begin
          add_cmd(($urandom_range(0, 99) < enq_pct) ? OP_ENQUEUE : OP_DEQUEUE,
                  pick_task_word(), IDLE_PLAN[m]);
          sent++;
        end
        segment++;
      end
    end

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // Sample on the falling edge, clear of the driver's updates.
    do @(negedge clk);
    while (ops_to_send.size() != 0 || start || cfg_write || in_flight != 0);
    repeat (TAIL_CYCLES) @(negedge clk);

    if (ring_replies.size() != 0) begin
      errors++;
      $display("%0t: %0d result words never arrived", $time, ring_replies.size());
    end
    if (errors == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
